// ===== rtl/fcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types and constants of the four-corner position unit.
// ----------------------------------------------------------------------------
package fcp_pkg;

  localparam int CFG_W = 24;
  localparam int IDX_W = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_A   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_B   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_C   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_K_SQUARE = 3'd6;
  localparam logic [IDX_W-1:0] REG_K_FOURTH = 3'd7;

  localparam logic [15:0] RST_GAIN_A   = 16'd6704;
  localparam logic [15:0] RST_GAIN_B   = 16'd6984;
  localparam logic [15:0] RST_GAIN_C   = 16'd10266;
  localparam logic [15:0] RST_GAIN_D   = 16'd10101;
  localparam logic [19:0] RST_K_SQUARE = 20'd16777;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ZERO    = 2'd1;
  localparam logic [1:0] STATUS_BAD_DEN = 2'd2;

  // correction divider geometry
  localparam int DEN_W  = 55;
  localparam int NUM2_W = 58;
  localparam int QUO2_W = 17;
  localparam int SIDE2_W = 34;

  typedef struct packed {
    logic [15:0] charge_a;
    logic [15:0] charge_b;
    logic [15:0] charge_c;
    logic [15:0] charge_d;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pos_x_raw;
    logic signed [15:0] pos_y_raw;
    logic signed [15:0] pos_x_fixed;
    logic signed [15:0] pos_y_fixed;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [19:0]        k_square;
    logic signed [23:0] k_fourth;
  } lens_cfg_t;

endpackage

// ===== rtl/four_corner_position_with_distortion_fix_unit.sv =====
// ----------------------------------------------------------------------------
// four_corner_position_with_distortion_fix_unit
// Charge-division position from four corner charges with radial correction.
// ----------------------------------------------------------------------------
//  channel   ports                          width
//  item      item_valid/item_ready/item     64
//  result    result_valid/result_ready/...  66
//  config    wr_en/wr_index/wr_data         3 + 24
//
//  one event per clock unless output stalls; path: front stages, Q1 =
//  clog2(HALF_SIDE*256+2) position divider cells, lens stages, 17 correction
//  divider cells, result register; one quotient bit per cell.
//  every stage holds a valid bit, so bubbles close up under output stall.
//  reset loads the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module four_corner_position_with_distortion_fix_unit import fcp_pkg::*; #(
  parameter int HALF_SIDE = 55
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [CFG_W-1:0]  wr_data
);

  localparam int HS_W = $clog2(HALF_SIDE + 1);
  localparam int Q1_W = $clog2(HALF_SIDE * 256 + 2);
  localparam int N1_W = 33 + HS_W + 9 + 1;
  localparam int D1_W = 35;

  // configuration registers
  logic [15:0] gain_a, gain_b, gain_c, gain_d;
  lens_cfg_t   cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_a       <= RST_GAIN_A;
      gain_b       <= RST_GAIN_B;
      gain_c       <= RST_GAIN_C;
      gain_d       <= RST_GAIN_D;
      cfg.centre_x <= '0;
      cfg.centre_y <= '0;
      cfg.k_square <= RST_K_SQUARE;
      cfg.k_fourth <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_A:   gain_a       <= wr_data[15:0];
        REG_GAIN_B:   gain_b       <= wr_data[15:0];
        REG_GAIN_C:   gain_c       <= wr_data[15:0];
        REG_GAIN_D:   gain_d       <= wr_data[15:0];
        REG_CENTRE_X: cfg.centre_x <= wr_data[15:0];
        REG_CENTRE_Y: cfg.centre_y <= wr_data[15:0];
        REG_K_SQUARE: cfg.k_square <= wr_data[19:0];
        REG_K_FOURTH: cfg.k_fourth <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  // front stages
  logic va, vb, vc, ea, eb, ec, div1_ready;
  assign ec = !vc || div1_ready;
  assign eb = !vb || ec;
  assign ea = !va || eb;
  assign item_ready = ea;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
    end else begin
      if (ea) va <= item_valid;
      if (eb) vb <= va;
      if (ec) vc <= vb;
    end
  end

  // stage a: gain normalization
  logic [31:0] na, nb, nc, nd;
  always_ff @(posedge clk) begin
    if (ea) begin
      na <= 32'(item.charge_a) * 32'(gain_a);
      nb <= 32'(item.charge_b) * 32'(gain_b);
      nc <= 32'(item.charge_c) * 32'(gain_c);
      nd <= 32'(item.charge_d) * 32'(gain_d);
    end
  end

  // stage b: sum and differences
  logic [33:0]        sum_b;
  logic signed [33:0] numx_b, numy_b;
  always_ff @(posedge clk) begin
    if (eb) begin
      sum_b  <= 34'(na) + 34'(nb) + 34'(nc) + 34'(nd);
      numx_b <= $signed(34'(nb) + 34'(nc)) - $signed(34'(na) + 34'(nd));
      numy_b <= $signed(34'(nc) + 34'(nd)) - $signed(34'(na) + 34'(nb));
    end
  end

  // stage c: rounded numerators 2*|num|*HS*256 + sum over divisor 2*sum
  logic [32:0]     ux, uy;
  logic [N1_W-1:0] n1x, n1y;
  logic [D1_W-1:0] d1;
  logic [2:0]      side1;
  assign ux = numx_b[33] ? 33'(-numx_b) : 33'(numx_b);
  assign uy = numy_b[33] ? 33'(-numy_b) : 33'(numy_b);

  always_ff @(posedge clk) begin
    if (ec) begin
      n1x   <= (N1_W'(ux) * N1_W'(HALF_SIDE) << 9) + N1_W'(sum_b);
      n1y   <= (N1_W'(uy) * N1_W'(HALF_SIDE) << 9) + N1_W'(sum_b);
      d1    <= {sum_b, 1'b0};
      side1 <= {sum_b == '0, numx_b[33], numy_b[33]};
    end
  end

  logic            q1_valid, q1_ready;
  logic [Q1_W-1:0] q1x, q1y;
  logic [2:0]      side1_out;

  fcp_divider #(.NW(N1_W), .DW(D1_W), .QW(Q1_W), .SW(3)) u_div_pos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vc),
    .in_ready (div1_ready),
    .num_x    (n1x),
    .num_y    (n1y),
    .div      (d1),
    .in_side  (side1),
    .out_valid(q1_valid),
    .out_ready(q1_ready),
    .quo_x    (q1x),
    .quo_y    (q1y),
    .out_side (side1_out)
  );

  logic signed [17:0] px, py;
  assign px = side1_out[1] ? -$signed(18'(q1x)) : $signed(18'(q1x));
  assign py = side1_out[0] ? -$signed(18'(q1y)) : $signed(18'(q1y));

  logic                lens_valid, div2_ready;
  logic [NUM2_W-1:0]   n2x, n2y;
  logic [DEN_W-1:0]    d2;
  logic [SIDE2_W-1:0]  side2;

  fcp_lens u_lens (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (q1_valid),
    .in_ready (q1_ready),
    .x        (px),
    .y        (py),
    .zero     (side1_out[2]),
    .out_valid(lens_valid),
    .out_ready(div2_ready),
    .num_x    (n2x),
    .num_y    (n2y),
    .div      (d2),
    .side     (side2)
  );

  logic               q2_valid, q2_ready;
  logic [QUO2_W-1:0]  q2x, q2y;
  logic [SIDE2_W-1:0] side2_out;

  fcp_divider #(.NW(NUM2_W), .DW(DEN_W), .QW(QUO2_W), .SW(SIDE2_W)) u_div_fix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lens_valid),
    .in_ready (div2_ready),
    .num_x    (n2x),
    .num_y    (n2y),
    .div      (d2),
    .in_side  (side2),
    .out_valid(q2_valid),
    .out_ready(q2_ready),
    .quo_x    (q2x),
    .quo_y    (q2y),
    .out_side (side2_out)
  );

  function automatic logic signed [15:0] fix16(input logic [QUO2_W-1:0] q,
                                               input logic neg);
    if (neg) begin
      if (q > QUO2_W'(32768)) return 16'sh8000;
      return 16'(-q);
    end
    if (q > QUO2_W'(32767)) return 16'sh7fff;
    return 16'(q);
  endfunction

  logic [1:0]         st;
  logic signed [15:0] xs, ys;
  result_t            result_next;
  assign st = side2_out[33:32];
  assign xs = side2_out[31:16];
  assign ys = side2_out[15:0];

  always_comb begin
    result_next.status      = st;
    result_next.pos_x_raw   = (st == STATUS_ZERO) ? '0 : xs;
    result_next.pos_y_raw   = (st == STATUS_ZERO) ? '0 : ys;
    result_next.pos_x_fixed = (st == STATUS_OK) ? fix16(q2x, xs[15]) : '0;
    result_next.pos_y_fixed = (st == STATUS_OK) ? fix16(q2y, ys[15]) : '0;
  end

  assign q2_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q2_ready) begin
      result_valid <= q2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q2_ready) begin
      result <= result_next;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == STATUS_OK || result.status == STATUS_ZERO ||
                      result.status == STATUS_BAD_DEN))
    else $error("undefined status code");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_ZERO) |->
      (result.pos_x_raw == '0 && result.pos_y_raw == '0 &&
       result.pos_x_fixed == '0 && result.pos_y_fixed == '0))
    else $error("zero sum result carries a position");

  a_bad_den_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_BAD_DEN) |->
      (result.pos_x_fixed == '0 && result.pos_y_fixed == '0))
    else $error("bad denominator result carries a corrected position");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    (!va && !vb && !vc) |-> item_ready)
    else $error("empty front stages refuse an item");

endmodule

// ===== rtl/fcp_div_cell.sv =====
// ----------------------------------------------------------------------------
// fcp_div_cell
// One restoring division step for two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module fcp_div_cell #(
  parameter int NW    = 52,
  parameter int DW    = 35,
  parameter int QW    = 16,
  parameter int SW    = 3,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] in_rem_x,
  input  logic [NW-1:0] in_rem_y,
  input  logic [DW-1:0] in_div,
  input  logic [QW-1:0] in_quo_x,
  input  logic [QW-1:0] in_quo_y,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NW-1:0] out_rem_x,
  output logic [NW-1:0] out_rem_y,
  output logic [DW-1:0] out_div,
  output logic [QW-1:0] out_quo_x,
  output logic [QW-1:0] out_quo_y,
  output logic [SW-1:0] out_side
);

  localparam int CW = ((NW > DW + SHIFT) ? NW : DW + SHIFT) + 1;

  logic [CW-1:0] step, ext_x, ext_y, diff_x, diff_y;
  logic          hit_x, hit_y;

  assign step   = CW'(in_div) << SHIFT;
  assign ext_x  = CW'(in_rem_x);
  assign ext_y  = CW'(in_rem_y);
  assign hit_x  = ext_x >= step;
  assign hit_y  = ext_y >= step;
  assign diff_x = ext_x - step;
  assign diff_y = ext_y - step;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_rem_x <= hit_x ? diff_x[NW-1:0] : in_rem_x;
      out_rem_y <= hit_y ? diff_y[NW-1:0] : in_rem_y;
      out_div   <= in_div;
      out_quo_x <= in_quo_x | (QW'(hit_x) << SHIFT);
      out_quo_y <= in_quo_y | (QW'(hit_y) << SHIFT);
      out_side  <= in_side;
    end
  end

endmodule

// ===== rtl/fcp_divider.sv =====
// ----------------------------------------------------------------------------
// fcp_divider
// Row of division cells, one quotient bit per cell, msb first.
// ----------------------------------------------------------------------------
module fcp_divider #(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int QW = 16,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num_x,
  input  logic [NW-1:0] num_y,
  input  logic [DW-1:0] div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quo_x,
  output logic [QW-1:0] quo_y,
  output logic [SW-1:0] out_side
);

  logic          v  [0:QW];
  logic          r  [0:QW];
  logic [NW-1:0] rx [0:QW];
  logic [NW-1:0] ry [0:QW];
  logic [DW-1:0] dv [0:QW];
  logic [QW-1:0] qx [0:QW];
  logic [QW-1:0] qy [0:QW];
  logic [SW-1:0] sd [0:QW];

  assign v[0]     = in_valid;
  assign in_ready = r[0];
  assign rx[0]    = num_x;
  assign ry[0]    = num_y;
  assign dv[0]    = div;
  assign qx[0]    = '0;
  assign qy[0]    = '0;
  assign sd[0]    = in_side;
  assign r[QW]    = out_ready;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    fcp_div_cell #(
      .NW(NW), .DW(DW), .QW(QW), .SW(SW), .SHIFT(QW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[i]),
      .in_ready (r[i]),
      .in_rem_x (rx[i]),
      .in_rem_y (ry[i]),
      .in_div   (dv[i]),
      .in_quo_x (qx[i]),
      .in_quo_y (qy[i]),
      .in_side  (sd[i]),
      .out_valid(v[i+1]),
      .out_ready(r[i+1]),
      .out_rem_x(rx[i+1]),
      .out_rem_y(ry[i+1]),
      .out_div  (dv[i+1]),
      .out_quo_x(qx[i+1]),
      .out_quo_y(qy[i+1]),
      .out_side (sd[i+1])
    );
  end

  assign out_valid = v[QW];
  assign quo_x     = qx[QW];
  assign quo_y     = qy[QW];
  assign out_side  = sd[QW];

endmodule

// ===== rtl/fcp_lens.sv =====
// ----------------------------------------------------------------------------
// fcp_lens
// Centring, r^2 and r^4, correction denominator and divider operands.
// ----------------------------------------------------------------------------
module fcp_lens import fcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  lens_cfg_t             cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [17:0]    x,
  input  logic signed [17:0]    y,
  input  logic                  zero,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUM2_W-1:0]     num_x,
  output logic [NUM2_W-1:0]     num_y,
  output logic [DEN_W-1:0]      div,
  output logic [SIDE2_W-1:0]    side
);

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7fff;
    if (v < -19'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic v1, v2, v3, v4, v5, v6, v7;
  logic e1, e2, e3, e4, e5, e6, e7;

  assign e7 = !v7 || out_ready;
  assign e6 = !v6 || e7;
  assign e5 = !v5 || e6;
  assign e4 = !v4 || e5;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign in_ready = e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      if (e1) v1 <= in_valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (e4) v4 <= v3;
      if (e5) v5 <= v4;
      if (e6) v6 <= v5;
      if (e7) v7 <= v6;
    end
  end

  // stage 1: centre and saturate
  logic signed [15:0] xs1, ys1;
  logic               z1;
  always_ff @(posedge clk) begin
    if (e1) begin
      xs1 <= sat16(19'(x) - 19'(cfg.centre_x));
      ys1 <= sat16(19'(y) - 19'(cfg.centre_y));
      z1  <= zero;
    end
  end

  // stage 2: squares
  logic signed [15:0] xs2, ys2;
  logic               z2;
  logic signed [31:0] sqx2, sqy2;
  always_ff @(posedge clk) begin
    if (e2) begin
      sqx2 <= xs1 * xs1;
      sqy2 <= ys1 * ys1;
      xs2  <= xs1;
      ys2  <= ys1;
      z2   <= z1;
    end
  end

  // stage 3: r^2 in q16.16
  logic signed [15:0] xs3, ys3;
  logic               z3;
  logic [31:0]        r2_3;
  always_ff @(posedge clk) begin
    if (e3) begin
      r2_3 <= 32'(sqx2) + 32'(sqy2);
      xs3  <= xs2;
      ys3  <= ys2;
      z3   <= z2;
    end
  end

  // stage 4: r2*r2 and k1*r2
  logic signed [15:0] xs4, ys4;
  logic               z4;
  logic [63:0]        r2sq4;
  logic [51:0]        kr2_4;
  always_ff @(posedge clk) begin
    if (e4) begin
      r2sq4 <= 64'(r2_3) * 64'(r2_3);
      kr2_4 <= 52'(cfg.k_square) * 52'(r2_3);
      xs4   <= xs3;
      ys4   <= ys3;
      z4    <= z3;
    end
  end

  // stage 5: k2*r4, r4 = floor(r2^2 / 2^32)
  logic signed [15:0] xs5, ys5;
  logic               z5;
  logic [51:0]        kr2_5;
  logic signed [56:0] kr4_5;
  always_ff @(posedge clk) begin
    if (e5) begin
      kr4_5 <= 57'(cfg.k_fourth) * $signed({25'd0, r2sq4[63:32]});
      kr2_5 <= kr2_4;
      xs5   <= xs4;
      ys5   <= ys4;
      z5    <= z4;
    end
  end

  // stage 6: denominator in q40
  logic signed [15:0] xs6, ys6;
  logic               z6;
  logic signed [58:0] den6;
  always_ff @(posedge clk) begin
    if (e6) begin
      den6 <= (59'sd1 <<< 40) + $signed({7'd0, kr2_5}) + 59'(kr4_5);
      xs6  <= xs5;
      ys6  <= ys5;
      z6   <= z5;
    end
  end

  // stage 7: rounded division operands
  logic        bad;
  logic [15:0] ax, ay;
  logic [1:0]  st;
  assign bad = den6[58] || (den6 == '0);
  assign ax  = xs6[15] ? 16'(-xs6) : 16'(xs6);
  assign ay  = ys6[15] ? 16'(-ys6) : 16'(ys6);

  always_comb begin
    if (z6) begin
      st = STATUS_ZERO;
    end else if (bad) begin
      st = STATUS_BAD_DEN;
    end else begin
      st = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (e7) begin
      num_x <= {1'b0, ax, 41'd0} + NUM2_W'(den6[53:0]);
      num_y <= {1'b0, ay, 41'd0} + NUM2_W'(den6[53:0]);
      div   <= {den6[53:0], 1'b0};
      side  <= {st, xs6, ys6};
    end
  end

  assign out_valid = v7;

endmodule
